// File: sv/bpa_pkg.sv
// bpa_pkg: shared constants, codes and control/status structs
// for the bitmap page allocator; no dependencies
package bpa_pkg;

	localparam int MAX_PAGES = 512;
	localparam int WORD_BITS = 32;
	localparam int MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int WIDX_W    = $clog2(MAP_WORDS);
	localparam int PAGE_W    = 9;
	localparam int CNT_W     = 10;
	localparam int LIM_W     = WIDX_W + 1;

	localparam logic [CNT_W-1:0] MAX_PAGES_C = CNT_W'(MAX_PAGES);

	typedef enum logic [1:0] {
		CMD_INIT  = 2'd0,
		CMD_ALLOC = 2'd1,
		CMD_FREE  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_BAD   = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	typedef enum logic {
		REG_FIRST_FREE = 1'b0,
		REG_PAGE_COUNT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic load;
		logic init_wr;
		logic scan_start;
		logic scan_step;
		logic take;
		logic set_empty;
		logic free_do;
		logic out_ld;
	} bpa_cmd_t;

	typedef struct packed {
		logic init_last;
		logic alloc_ok;
		logic word_hit;
		logic scan_last;
		logic out_free;
	} bpa_stat_t;

endpackage

// File: sv/bpa_ctrl.sv
// bpa_ctrl: request sequencer for the page allocator
// depends on bpa_pkg
module bpa_ctrl import bpa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic [1:0] req_cmd,
	output logic      req_ready,
	input  bpa_stat_t stat,
	output bpa_cmd_t  ctl
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_INIT   = 6'b000010,
		S_ASTART = 6'b000100,
		S_SCAN   = 6'b001000,
		S_FREE   = 6'b010000,
		S_FIN    = 6'b100000
	} state_t;

	state_t state_q, state_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					ctl.load = 1'b1;
					case (cmd_t'(req_cmd))
						CMD_INIT:  state_d = S_INIT;
						CMD_ALLOC: state_d = S_ASTART;
						CMD_FREE:  state_d = S_FREE;
						default:   state_d = S_FIN;
					endcase
				end
			end
			S_INIT: begin
				ctl.init_wr = 1'b1;
				if (stat.init_last)
					state_d = S_FIN;
			end
			S_ASTART: begin
				if (stat.alloc_ok) begin
					ctl.scan_start = 1'b1;
					state_d = S_SCAN;
				end else begin
					ctl.set_empty = 1'b1;
					state_d = S_FIN;
				end
			end
			S_SCAN: begin
				if (stat.word_hit) begin
					ctl.take = 1'b1;
					state_d = S_FIN;
				end else if (stat.scan_last) begin
					ctl.set_empty = 1'b1;
					state_d = S_FIN;
				end else begin
					ctl.scan_step = 1'b1;
				end
			end
			S_FREE: begin
				ctl.free_do = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (stat.out_free) begin
					ctl.out_ld = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// File: sv/bpa_dp.sv
// bpa_dp: free map, counters, configuration registers and result register
// depends on bpa_pkg
module bpa_dp import bpa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_addr,
	input  logic [CNT_W-1:0]  cfg_wdata,
	input  logic [PAGE_W-1:0] req_page,
	input  bpa_cmd_t          ctl,
	output bpa_stat_t         stat,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        out_status,
	output logic [PAGE_W-1:0] out_page,
	output logic [CNT_W-1:0]  out_count
);

	logic [CNT_W-1:0]     ffp_q, pc_q;
	logic [WORD_BITS-1:0] map_q [MAP_WORDS];
	logic [WIDX_W-1:0]    scan_word_q, idx_q, w_q, n_q;
	logic [CNT_W-1:0]     free_q;
	logic [PAGE_W-1:0]    page_q;
	status_t              res_status_q;
	logic [PAGE_W-1:0]    res_page_q;
	logic                 out_valid_q;
	status_t              out_status_q;
	logic [PAGE_W-1:0]    out_page_q;
	logic [CNT_W-1:0]     out_count_q;

	logic [CNT_W-1:0]     lo, hi, init_cnt;
	logic [CNT_W:0]       hi_round;
	logic [LIM_W-1:0]     limit;
	logic [WIDX_W-1:0]    start_w;
	logic [WORD_BITS-1:0] init_mask, cur_word, low_one;
	logic [BIT_W-1:0]     low_idx;
	logic [WIDX_W-1:0]    fw;
	logic [BIT_W-1:0]     fb;
	logic                 free_bad;

	assign lo       = (ffp_q > MAX_PAGES_C) ? MAX_PAGES_C : ffp_q;
	assign hi       = (pc_q > MAX_PAGES_C) ? MAX_PAGES_C : pc_q;
	assign init_cnt = (hi > lo) ? (hi - lo) : '0;
	assign hi_round = {1'b0, hi} + (CNT_W+1)'(WORD_BITS - 1);
	assign limit    = LIM_W'(hi_round >> BIT_W);
	assign start_w  = ({1'b0, scan_word_q} < limit) ? scan_word_q : '0;

	// bits of the swept word that fall inside [lo, hi)
	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			init_mask[b] = ({1'b0, idx_q, BIT_W'(b)} >= lo) &&
			               ({1'b0, idx_q, BIT_W'(b)} < hi);
		end
	end

	// lowest set bit of the scanned word
	assign cur_word = map_q[w_q];
	assign low_one  = cur_word & (~cur_word + WORD_BITS'(1));
	always_comb begin
		low_idx = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			if (low_one[b])
				low_idx = low_idx | BIT_W'(b);
		end
	end

	assign fw       = page_q[PAGE_W-1:BIT_W];
	assign fb       = page_q[BIT_W-1:0];
	assign free_bad = ({1'b0, page_q} >= hi) || map_q[fw][fb];

	assign stat.init_last = (idx_q == WIDX_W'(MAP_WORDS - 1));
	assign stat.alloc_ok  = (free_q != '0) && (limit != '0);
	assign stat.word_hit  = (cur_word != '0);
	assign stat.scan_last = ({1'b0, n_q} == (limit - LIM_W'(1)));
	assign stat.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ffp_q <= '0;
			pc_q  <= MAX_PAGES_C;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_FIRST_FREE: ffp_q <= cfg_wdata;
				REG_PAGE_COUNT: pc_q  <= cfg_wdata;
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAP_WORDS; i++)
				map_q[i] <= '0;
			scan_word_q <= '0;
			free_q      <= '0;
			idx_q       <= '0;
			w_q         <= '0;
			n_q         <= '0;
		end else begin
			if (ctl.load)
				idx_q <= '0;
			if (ctl.init_wr) begin
				map_q[idx_q] <= init_mask;
				idx_q        <= idx_q + WIDX_W'(1);
				if (stat.init_last)
					free_q <= init_cnt;
			end
			if (ctl.scan_start) begin
				w_q <= start_w;
				n_q <= '0;
			end
			if (ctl.scan_step) begin
				w_q <= ({1'b0, w_q} == (limit - LIM_W'(1))) ? '0 : w_q + WIDX_W'(1);
				n_q <= n_q + WIDX_W'(1);
			end
			if (ctl.take) begin
				map_q[w_q]  <= cur_word & ~low_one;
				scan_word_q <= w_q;
				free_q      <= free_q - CNT_W'(1);
			end
			if (ctl.free_do && !free_bad) begin
				map_q[fw][fb] <= 1'b1;
				free_q        <= free_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			page_q       <= req_page;
			res_status_q <= ST_OK;
			res_page_q   <= '0;
		end
		if (ctl.set_empty)
			res_status_q <= ST_EMPTY;
		if (ctl.take)
			res_page_q <= {w_q, low_idx};
		if (ctl.free_do && free_bad)
			res_status_q <= ST_BAD;
		if (ctl.out_ld) begin
			out_status_q <= res_status_q;
			out_page_q   <= res_page_q;
			out_count_q  <= free_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctl.out_ld)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_page   = out_page_q;
	assign out_count  = out_count_q;

endmodule

// File: sv/bitmap_page_allocator.sv
// bitmap_page_allocator: top level joining the sequencer and the datapath
// depends on bpa_pkg, bpa_ctrl, bpa_dp
// allocate scans one map word per cycle, init rewrites one map word per cycle
// one request in flight; next input accepted the cycle after the result is registered
// reset: free map cleared, word pointer and free count zero, first_free_page 0, page_count 512
module bitmap_page_allocator import bpa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [9:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // page_in[8:0], zero fill
	input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // page_out[8:0], free_count[18:9], zero fill
	output logic [1:0]  m_axis_tuser   // status[1:0]
);

	bpa_cmd_t          ctl;
	bpa_stat_t         stat;
	logic [PAGE_W-1:0] page_out;
	logic [CNT_W-1:0]  free_count;

	bpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_cmd   (s_axis_tuser),
		.req_ready (s_axis_tready),
		.stat      (stat),
		.ctl       (ctl)
	);

	bpa_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.req_page   (s_axis_tdata[PAGE_W-1:0]),
		.ctl        (ctl),
		.stat       (stat),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (m_axis_tuser),
		.out_page   (page_out),
		.out_count  (free_count)
	);

	assign m_axis_tdata = {5'b0, free_count, page_out};

endmodule

// File: bench/bitmap_page_allocator_tb.sv
// bitmap_page_allocator_tb: self-checking bench for the bitmap page allocator
// drives init/alloc/free and unused-code requests and register writes, predicts each result and
// checks it; depends on bpa_pkg and bitmap_page_allocator
module bitmap_page_allocator_tb;
	import bpa_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 115;

	typedef struct {
		status_t          status;
		logic [8:0]       page;
		logic [CNT_W-1:0] count;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_addr;
	logic [9:0]  cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	// shadow of the allocator
	logic [WORD_BITS-1:0] shadow_map [MAP_WORDS];
	int                   shadow_ptr;
	logic [CNT_W-1:0]     shadow_free;
	logic [9:0]           reg_first_free;
	logic [9:0]           reg_page_count;

	outcome_t   pending_outcomes [$];
	logic [8:0] pages_in_use [$];
	int         mismatches = 0;
	int         burst_left = 0;
	int         holdoff_left = 0;
	int         quiet_cycles = 0;

	bitmap_page_allocator uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [9:0] clamp_pages(input logic [9:0] v);
		return (v > MAX_PAGES_C) ? MAX_PAGES_C : v;
	endfunction

	function automatic outcome_t allocator_outcome(input cmd_t c, input logic [8:0] p);
		outcome_t o;
		int       lo, hi, lim, w, n, b;
		logic     found, hit;
		o.status = ST_OK;
		o.page   = '0;
		case (c)
			CMD_INIT: begin
				lo = int'(clamp_pages(reg_first_free));
				hi = int'(clamp_pages(reg_page_count));
				for (w = 0; w < MAP_WORDS; w++)
					shadow_map[w] = '0;
				shadow_free = '0;
				for (n = lo; n < hi; n++) begin
					shadow_map[n / WORD_BITS][n % WORD_BITS] = 1'b1;
					shadow_free++;
				end
				pages_in_use.delete();
			end
			CMD_ALLOC: begin
				lim   = (int'(clamp_pages(reg_page_count)) + WORD_BITS - 1) / WORD_BITS;
				found = 1'b0;
				w     = 0;
				if (shadow_free != '0 && lim != 0) begin
					w = (shadow_ptr < lim) ? shadow_ptr : 0;
					for (n = 0; n < lim && !found; n++) begin
						if (shadow_map[w] != '0)
							found = 1'b1;
						else
							w = (w + 1 >= lim) ? 0 : w + 1;
					end
				end
				if (found) begin
					b   = 0;
					hit = 1'b0;
					for (n = 0; n < WORD_BITS && !hit; n++) begin
						if (shadow_map[w][n]) begin
							b   = n;
							hit = 1'b1;
						end
					end
					shadow_map[w][b] = 1'b0;
					shadow_ptr       = w;
					shadow_free--;
					o.page = 9'(w * WORD_BITS + b);
					pages_in_use.push_back(o.page);
				end else begin
					o.status = ST_EMPTY;
				end
			end
			CMD_FREE: begin
				if (p >= clamp_pages(reg_page_count) || shadow_map[p / WORD_BITS][p % WORD_BITS]) begin
					o.status = ST_BAD;
				end else begin
					shadow_map[p / WORD_BITS][p % WORD_BITS] = 1'b1;
					shadow_free++;
				end
			end
			default: ;
		endcase
		o.count = shadow_free;
		return o;
	endfunction

	task automatic send_request(input cmd_t c, input logic [8:0] p);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= c;
		s_axis_tdata  <= {7'b0, p};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_outcomes.push_back(allocator_outcome(c, p));
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_axis_tvalid <= 1'b0;
			gap = $urandom_range(1, 10);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
			                                         : $urandom_range(1, 12);
		end
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		// let the block settle after its last result
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [9:0] v);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_FIRST_FREE)
			reg_first_free = v;
		else
			reg_page_count = v;
	endtask

	task automatic note_mismatch(input string field, input int exp_v, input int act_v);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s: expected %0d, got %0d", field, exp_v, act_v);
	endtask

	// result checker
	always @(posedge clk) begin
		outcome_t o;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_outcomes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d page %0d count %0d",
					         m_axis_tuser, m_axis_tdata[8:0], m_axis_tdata[18:9]);
			end else begin
				o = pending_outcomes.pop_front();
				if (m_axis_tuser !== o.status)
					note_mismatch("status", o.status, m_axis_tuser);
				if (m_axis_tdata[8:0] !== o.page)
					note_mismatch("page_out", o.page, m_axis_tdata[8:0]);
				if (m_axis_tdata[18:9] !== o.count)
					note_mismatch("free_count", o.count, m_axis_tdata[18:9]);
			end
		end
	end

	// receiver stall pattern, with an optional long hold-off
	initial begin
		int pat_mode, pat_left, cyc;
		pat_mode = 0;
		pat_left = 0;
		cyc      = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (pat_left == 0) begin
				pat_mode = $urandom_range(0, 3);
				pat_left = $urandom_range(20, 80);
			end else begin
				pat_left--;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				m_axis_tready <= 1'b0;
			end else begin
				case (pat_mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= (cyc % 4 == 0);
					default: m_axis_tready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("bitmap_page_allocator regression: fail");
			$finish;
		end
	end

	task automatic test_reset_state();
		int w;
		for (w = 0; w < MAP_WORDS; w++)
			shadow_map[w] = '0;
		shadow_ptr     = 0;
		shadow_free    = '0;
		reg_first_free = '0;
		reg_page_count = 10'd512;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// empty map and zero count straight out of reset
		send_request(CMD_ALLOC, 9'd0);
		send_request(CMD_NONE, 9'd0);
	endtask

	task automatic test_directed_cases();
		// free before any init, then allocate it back from the top word
		send_request(CMD_FREE, 9'd511);
		send_request(CMD_ALLOC, 9'd0);
		send_request(CMD_INIT, 9'd0);
		send_request(CMD_ALLOC, 9'd0);
		send_request(CMD_ALLOC, 9'd0);
		// first free page not below page count
		write_reg(REG_PAGE_COUNT, 10'd40);
		write_reg(REG_FIRST_FREE, 10'd40);
		send_request(CMD_INIT, 9'd0);
		send_request(CMD_ALLOC, 9'd0);
		// saturated registers
		write_reg(REG_PAGE_COUNT, 10'h3FF);
		write_reg(REG_FIRST_FREE, 10'h3FF);
		send_request(CMD_INIT, 9'd0);
		write_reg(REG_FIRST_FREE, 10'd500);
		send_request(CMD_INIT, 9'd0);
		send_request(CMD_ALLOC, 9'd0);
		send_request(CMD_FREE, 9'd500);
		send_request(CMD_FREE, 9'd500);
		send_request(CMD_FREE, 9'd0);
		// page count lowered after frees, pointer beyond the scanned words
		write_reg(REG_PAGE_COUNT, 10'd20);
		send_request(CMD_ALLOC, 9'd0);
		send_request(CMD_ALLOC, 9'd0);
		send_request(CMD_FREE, 9'd25);
		send_request(CMD_FREE, 9'd511);
		write_reg(REG_PAGE_COUNT, 10'd0);
		send_request(CMD_ALLOC, 9'd0);
		send_request(CMD_INIT, 9'd0);
		write_reg(REG_FIRST_FREE, 10'd0);
		write_reg(REG_PAGE_COUNT, 10'd512);
		send_request(CMD_INIT, 9'd0);
		send_request(CMD_NONE, 9'd511);
	endtask

	task automatic test_input_backpressure();
		int i;
		wait_idle();
		burst_left   = 200;
		holdoff_left = 300;
		for (i = 0; i < 20; i++) begin
			if (i % 3 == 2 && pages_in_use.size() != 0)
				send_request(CMD_FREE, pages_in_use.pop_front());
			else
				send_request(CMD_ALLOC, 9'd0);
		end
		wait_idle();
		burst_left = 0;
	endtask

	task automatic test_random_traffic();
		int         ph, i, r, k;
		logic [9:0] pc, ff;
		logic [8:0] pg;
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin ff = 10'd0; pc = 10'd512; end
				1: begin ff = 10'd0; pc = 10'h3FF; end
				2: begin ff = 10'd5; pc = 10'd1; end
				3: begin ff = 10'd0; pc = 10'd32; end
				default: begin
					pc = 10'($urandom_range(1, 160));
					ff = 10'($urandom_range(0, pc + 8));
				end
			endcase
			write_reg(REG_FIRST_FREE, ff);
			write_reg(REG_PAGE_COUNT, pc);
			send_request(CMD_INIT, 9'($urandom_range(0, 511)));
			for (i = 0; i < PHASE_ITEMS; i++) begin
				if (ph % 2 == 1 && i == PHASE_ITEMS / 2)
					write_reg(REG_PAGE_COUNT, 10'($urandom_range(0, pc)));
				r = $urandom_range(0, 99);
				if (r < 48 || (r < 83 && pages_in_use.size() == 0)) begin
					send_request(CMD_ALLOC, 9'($urandom_range(0, 511)));
				end else if (r < 83) begin
					k  = $urandom_range(0, pages_in_use.size() - 1);
					pg = pages_in_use[k];
					pages_in_use.delete(k);
					send_request(CMD_FREE, pg);
				end else if (r < 93) begin
					send_request(CMD_FREE, 9'($urandom_range(0, 511)));
				end else if (r < 97) begin
					send_request(CMD_INIT, 9'($urandom_range(0, 511)));
				end else begin
					send_request(CMD_NONE, 9'($urandom_range(0, 511)));
				end
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_addr      = 1'b0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		test_reset_state();
		test_directed_cases();
		test_input_backpressure();
		test_random_traffic();
		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_outcomes.size() == 0)
			$display("bitmap_page_allocator regression: pass");
		else
			$display("bitmap_page_allocator regression: fail");
		$finish;
	end

endmodule
